>>> sv/vector_angle_classifier_core_assert.svh
// Assertion macros shared by the vector angle classifier RTL.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef VECTOR_ANGLE_CLASSIFIER_CORE_ASSERT_SVH
`define VECTOR_ANGLE_CLASSIFIER_CORE_ASSERT_SVH

// The condition must hold at every clock edge.
`define VAC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in any cycle where the antecedent holds.
`define VAC_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> sv/vac_pkg.sv
`timescale 1ns / 1ps

package vac_pkg;

    typedef enum logic [1:0] {
        REL_NOT_ORTHO   = 2'd0,
        REL_ORTHONORMAL = 2'd1,
        REL_ORTHOGONAL  = 2'd2
    } relation_t;

    typedef struct packed {
        logic      zero;
        logic      cross_zero;
        logic      dot_neg;
        logic      dot_zero;
        relation_t rel;
    } vac_flags_t;

    // Angle accumulator: degrees in Q.16, signed.
    localparam int ZW = 26;
    localparam logic signed [ZW-1:0] DEG90_Q16  = 26'sd5898240;
    localparam logic signed [ZW-1:0] DEG180_Q16 = 26'sd11796480;
    localparam logic [ZW-1:0]        ROUND_HALF = 26'd128;

    localparam int MAX_ATAN_STAGES = 24;
    localparam int ATAN_W = 22;

    // atan(2^-i) in degrees, Q.16.
    localparam logic [ATAN_W-1:0] ATAN_TABLE [0:MAX_ATAN_STAGES-1] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
        22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
    };

    // Squared length of a unit vector with 8 fraction bits.
    localparam int UNIT_SQ = 65536;

    localparam int ANGLE_W  = 16;
    localparam int LEN_W    = 16;
    localparam int SUM_W    = 17;
    localparam int SLEN_W   = 17;
    localparam int OUT_BITS = 3 * LEN_W + 3 * SUM_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

endpackage

>>> sv/vector_angle_classifier_core.sv
`timescale 1ns / 1ps
// Vector angle classifier: for each pair of 2D vectors (signed Q7.8) it returns the
// angle between them in degrees (Q8.8, 0 to 180), both lengths, the sum vector with
// its length, an orthogonality class and a zero-vector flag.
// Input: one transfer on s_tvalid/s_tready carries both vectors in s_tdata.
// Output: one transfer on m_tvalid/m_tready carries the results in m_tdata and the
// class and zero flag in m_tuser. Every input transfer yields exactly one output
// transfer, in order.
// Throughput is one pair per cycle while the receiver does not stall. Below,
// D = max(CORDIC_STAGES, COORD_WIDTH + 1): four front stages form the products,
// dot, cross and squared lengths; D stages each run at most one CORDIC rotation
// and one square-root digit per length; the last stage rounds and holds the
// result. Every stage has its own valid bit and moves when the stage after it
// is empty or moving, so bubbles are squeezed out and input keeps being taken
// while a finished result waits at the output. When the receiver stalls, the
// pipeline fills and s_tready falls once every stage holds an item; nothing is
// dropped or repeated. Reset clears all valid bits; the data registers are not
// reset.
`include "vector_angle_classifier_core_assert.svh"

module vector_angle_classifier_core #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // first_x, first_y, second_x, second_y (COORD_WIDTH bits each), zero padding
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // angle_degrees[15:0], first_length[31:16], second_length[47:32],
    // sum_x[64:48], sum_y[81:65], sum_length[98:82], zero padding
    output logic [vac_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // relation[1:0], zero_vector[2]
    output logic [2:0]                           m_tuser
);
    import vac_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int NW = 2 * W + 2;
    localparam int RS = W + 1;
    localparam int CW = 2 * W + 3;
    localparam int D  = (CORDIC_STAGES > RS) ? CORDIC_STAGES : RS;

    logic                 sv_s   [0:D];
    logic                 rdy_s  [0:D];
    logic signed [CW-1:0] x_s    [0:D];
    logic signed [CW-1:0] y_s    [0:D];
    logic signed [ZW-1:0] z_s    [0:D];
    logic [2:0][NW-1:0]   rad_s  [0:D];
    logic [2:0][RS+1:0]   rem_s  [0:D];
    logic [2:0][RS-1:0]   root_s [0:D];
    vac_flags_t           fl_s   [0:D];
    logic signed [W:0]    sx_s   [0:D];
    logic signed [W:0]    sy_s   [0:D];

    logic [ANGLE_W-1:0] angle;
    logic [LEN_W-1:0]   len1, len2;
    logic [SUM_W-1:0]   sum_x, sum_y;
    logic [SLEN_W-1:0]  sum_len;
    relation_t          relation;
    logic               zero;

    vac_front #(.W(W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .x1        (s_tdata[0*W +: W]),
        .y1        (s_tdata[1*W +: W]),
        .x2        (s_tdata[2*W +: W]),
        .y2        (s_tdata[3*W +: W]),
        .out_valid (sv_s[0]),
        .out_ready (rdy_s[0]),
        .cx        (x_s[0]),
        .cy        (y_s[0]),
        .cz        (z_s[0]),
        .rad       (rad_s[0]),
        .flags     (fl_s[0]),
        .sx        (sx_s[0]),
        .sy        (sy_s[0])
    );

    // The root and remainder start empty; each square-root stage brings in two radicand bits.
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;

    for (genvar i = 0; i < D; i++)
    begin : g_iter
        vac_iter #(.W(W), .IDX(i), .NUM_CORDIC(CORDIC_STAGES)) u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sv_s[i]),
            .in_ready  (rdy_s[i]),
            .in_x      (x_s[i]),
            .in_y      (y_s[i]),
            .in_z      (z_s[i]),
            .in_rad    (rad_s[i]),
            .in_rem    (rem_s[i]),
            .in_root   (root_s[i]),
            .in_flags  (fl_s[i]),
            .in_sx     (sx_s[i]),
            .in_sy     (sy_s[i]),
            .out_valid (sv_s[i+1]),
            .out_ready (rdy_s[i+1]),
            .out_x     (x_s[i+1]),
            .out_y     (y_s[i+1]),
            .out_z     (z_s[i+1]),
            .out_rad   (rad_s[i+1]),
            .out_rem   (rem_s[i+1]),
            .out_root  (root_s[i+1]),
            .out_flags (fl_s[i+1]),
            .out_sx    (sx_s[i+1]),
            .out_sy    (sy_s[i+1])
        );
    end

    vac_back #(.W(W)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sv_s[D]),
        .in_ready  (rdy_s[D]),
        .in_z      (z_s[D]),
        .in_rem    (rem_s[D]),
        .in_root   (root_s[D]),
        .in_flags  (fl_s[D]),
        .in_sx     (sx_s[D]),
        .in_sy     (sy_s[D]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .angle     (angle),
        .len1      (len1),
        .len2      (len2),
        .sum_x     (sum_x),
        .sum_y     (sum_y),
        .sum_len   (sum_len),
        .relation  (relation),
        .zero      (zero)
    );

    assign m_tdata = {(OUT_TDATA_W - OUT_BITS)'(0), sum_len, sum_y, sum_x, len2, len1, angle};
    assign m_tuser = {zero, relation};

    // A zero vector always reports an angle of zero.
    `VAC_ASSERT_IMPLIES(a_zero_angle, m_tvalid && zero, angle == '0, "zero vector with angle")
    // The angle never leaves 0 to 180 degrees.
    `VAC_ASSERT_IMPLIES(a_angle_range, m_tvalid, angle <= ANGLE_W'(46080), "angle out of range")
    // Orthonormal pairs cannot contain a zero vector.
    `VAC_ASSERT_IMPLIES(a_ortho_nonzero, m_tvalid && relation == REL_ORTHONORMAL, !zero,
        "orthonormal with zero vector")
    // A zero vector makes the dot product zero, so the class is orthogonal.
    `VAC_ASSERT_IMPLIES(a_zero_class, m_tvalid && zero, relation == REL_ORTHOGONAL,
        "zero vector not orthogonal")
    // The output stage is ready exactly when it is empty or the receiver takes its result.
    `VAC_ASSERT_ALWAYS(a_back_ready, rdy_s[D] == (!m_tvalid || m_tready),
        "output stage ready mismatch")

endmodule

>>> sv/vac_front.sv
`timescale 1ns / 1ps

module vac_front #(
    parameter int W = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [W-1:0]          x1,
    input  logic signed [W-1:0]          y1,
    input  logic signed [W-1:0]          x2,
    input  logic signed [W-1:0]          y2,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [2*W+2:0]        cx,
    output logic signed [2*W+2:0]        cy,
    output logic signed [vac_pkg::ZW-1:0] cz,
    output logic [2:0][2*W+1:0]          rad,
    output vac_pkg::vac_flags_t          flags,
    output logic signed [W:0]            sx,
    output logic signed [W:0]            sy
);
    import vac_pkg::*;

    localparam int PW = 2 * W;
    localparam int DW = 2 * W + 1;
    localparam int NW = 2 * W + 2;
    localparam int CW = 2 * W + 3;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ce1, ce2, ce3, ce4;

    // Stage 1: inputs, sums, zero detection.
    logic signed [W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [W:0]   sx1_reg, sy1_reg;
    logic                zero1_reg;
    // Stage 2: products.
    logic signed [PW-1:0] pxx_reg, pyy_reg, pxy_reg, pyx_reg;
    logic signed [PW-1:0] sqx1_reg, sqy1_reg, sqx2_reg, sqy2_reg;
    logic signed [NW-1:0] sqsx_reg, sqsy_reg;
    logic signed [W:0]    sx2_reg, sy2_reg;
    logic                 zero2_reg;
    // Stage 3: dot, cross, squared norms.
    logic signed [DW-1:0] dot_reg, cross_reg;
    logic [NW-1:0]        n1_reg, n2_reg, ns_reg;
    logic signed [W:0]    sx3_reg, sy3_reg;
    logic                 zero3_reg;
    // Stage 4: CORDIC start vector and class flags.
    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic [2:0][NW-1:0]   rad_reg;
    vac_flags_t           flags_reg;
    logic signed [W:0]    sx4_reg, sy4_reg;

    logic signed [DW-1:0] cabs;
    logic                 unit_both;

    assign ce4 = !v4_reg || out_ready;
    assign ce3 = !v3_reg || ce4;
    assign ce2 = !v2_reg || ce3;
    assign ce1 = !v1_reg || ce2;
    assign in_ready = ce1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ce1) v1_reg <= in_valid;
            if (ce2) v2_reg <= v1_reg;
            if (ce3) v3_reg <= v2_reg;
            if (ce4) v4_reg <= v3_reg;
        end
    end

    assign cabs = (cross_reg < 0) ? -cross_reg : cross_reg;
    assign unit_both = (n1_reg == NW'(UNIT_SQ)) && (n2_reg == NW'(UNIT_SQ));

    always_ff @(posedge clk)
    begin
        if (ce1 && in_valid)
        begin
            x1_reg    <= x1;
            y1_reg    <= y1;
            x2_reg    <= x2;
            y2_reg    <= y2;
            sx1_reg   <= (W+1)'(x1) + (W+1)'(x2);
            sy1_reg   <= (W+1)'(y1) + (W+1)'(y2);
            zero1_reg <= ((x1 == '0) && (y1 == '0)) || ((x2 == '0) && (y2 == '0));
        end
        if (ce2 && v1_reg)
        begin
            pxx_reg   <= PW'(x1_reg) * PW'(x2_reg);
            pyy_reg   <= PW'(y1_reg) * PW'(y2_reg);
            pxy_reg   <= PW'(x1_reg) * PW'(y2_reg);
            pyx_reg   <= PW'(y1_reg) * PW'(x2_reg);
            sqx1_reg  <= PW'(x1_reg) * PW'(x1_reg);
            sqy1_reg  <= PW'(y1_reg) * PW'(y1_reg);
            sqx2_reg  <= PW'(x2_reg) * PW'(x2_reg);
            sqy2_reg  <= PW'(y2_reg) * PW'(y2_reg);
            sqsx_reg  <= NW'(sx1_reg) * NW'(sx1_reg);
            sqsy_reg  <= NW'(sy1_reg) * NW'(sy1_reg);
            sx2_reg   <= sx1_reg;
            sy2_reg   <= sy1_reg;
            zero2_reg <= zero1_reg;
        end
        if (ce3 && v2_reg)
        begin
            dot_reg   <= DW'(pxx_reg) + DW'(pyy_reg);
            cross_reg <= DW'(pxy_reg) - DW'(pyx_reg);
            n1_reg    <= NW'(unsigned'(sqx1_reg)) + NW'(unsigned'(sqy1_reg));
            n2_reg    <= NW'(unsigned'(sqx2_reg)) + NW'(unsigned'(sqy2_reg));
            ns_reg    <= unsigned'(sqsx_reg) + unsigned'(sqsy_reg);
            sx3_reg   <= sx2_reg;
            sy3_reg   <= sy2_reg;
            zero3_reg <= zero2_reg;
        end
        if (ce4 && v3_reg)
        begin
            // Vectoring starts in the right half plane; an obtuse pair is
            // rotated by 90 degrees first.
            if (dot_reg < 0)
            begin
                cx_reg <= CW'(cabs);
                cy_reg <= -CW'(dot_reg);
                cz_reg <= DEG90_Q16;
            end
            else
            begin
                cx_reg <= CW'(dot_reg);
                cy_reg <= CW'(cabs);
                cz_reg <= '0;
            end
            rad_reg[0]           <= n1_reg;
            rad_reg[1]           <= n2_reg;
            rad_reg[2]           <= ns_reg;
            flags_reg.zero       <= zero3_reg;
            flags_reg.cross_zero <= (cross_reg == '0);
            flags_reg.dot_neg    <= (dot_reg < 0);
            flags_reg.dot_zero   <= (dot_reg == '0);
            if (dot_reg != '0)
                flags_reg.rel <= REL_NOT_ORTHO;
            else if (unit_both)
                flags_reg.rel <= REL_ORTHONORMAL;
            else
                flags_reg.rel <= REL_ORTHOGONAL;
            sx4_reg <= sx3_reg;
            sy4_reg <= sy3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign cx    = cx_reg;
    assign cy    = cy_reg;
    assign cz    = cz_reg;
    assign rad   = rad_reg;
    assign flags = flags_reg;
    assign sx    = sx4_reg;
    assign sy    = sy4_reg;

endmodule

>>> sv/vac_iter.sv
`timescale 1ns / 1ps

module vac_iter #(
    parameter int W          = 16,
    parameter int IDX        = 0,
    parameter int NUM_CORDIC = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [2*W+2:0]         in_x,
    input  logic signed [2*W+2:0]         in_y,
    input  logic signed [vac_pkg::ZW-1:0] in_z,
    input  logic [2:0][2*W+1:0]           in_rad,
    input  logic [2:0][W+2:0]             in_rem,
    input  logic [2:0][W:0]               in_root,
    input  vac_pkg::vac_flags_t           in_flags,
    input  logic signed [W:0]             in_sx,
    input  logic signed [W:0]             in_sy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [2*W+2:0]         out_x,
    output logic signed [2*W+2:0]         out_y,
    output logic signed [vac_pkg::ZW-1:0] out_z,
    output logic [2:0][2*W+1:0]           out_rad,
    output logic [2:0][W+2:0]             out_rem,
    output logic [2:0][W:0]               out_root,
    output vac_pkg::vac_flags_t           out_flags,
    output logic signed [W:0]             out_sx,
    output logic signed [W:0]             out_sy
);
    import vac_pkg::*;

    localparam int NW = 2 * W + 2;
    localparam int RS = W + 1;
    localparam int CW = 2 * W + 3;
    localparam bit DO_CORDIC = (IDX < NUM_CORDIC) && (IDX < MAX_ATAN_STAGES);
    localparam bit DO_SQRT   = (IDX < RS);
    localparam int TIDX = (IDX < MAX_ATAN_STAGES) ? IDX : 0;
    localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(ATAN_TABLE[TIDX]);

    logic                 v_reg;
    logic                 ce;
    logic signed [CW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [2:0][NW-1:0]   rad_reg, rad_next;
    logic [2:0][RS+1:0]   rem_reg, rem_next;
    logic [2:0][RS-1:0]   root_reg, root_next;
    vac_flags_t           flags_reg;
    logic signed [W:0]    sx_reg, sy_reg;

    assign ce = !v_reg || out_ready;
    assign in_ready = ce;

    // One CORDIC micro-rotation; shifts round toward minus infinity.
    always_comb
    begin
        if (DO_CORDIC)
        begin
            if (in_y > 0)
            begin
                x_next = in_x + (in_y >>> IDX);
                y_next = in_y - (in_x >>> IDX);
                z_next = in_z + ATAN_STEP;
            end
            else
            begin
                x_next = in_x - (in_y >>> IDX);
                y_next = in_y + (in_x >>> IDX);
                z_next = in_z - ATAN_STEP;
            end
        end
        else
        begin
            x_next = in_x;
            y_next = in_y;
            z_next = in_z;
        end
    end

    // One restoring square-root digit per lane: two radicand bits in, one root bit out.
    always_comb
    begin
        logic [RS+3:0] rem_sh;
        logic [RS+3:0] trial;
        for (int l = 0; l < 3; l++)
        begin
            rem_sh = {in_rem[l], in_rad[l][NW-1 -: 2]};
            trial  = {2'b00, in_root[l], 2'b01};
            if (!DO_SQRT)
            begin
                rem_next[l]  = in_rem[l];
                root_next[l] = in_root[l];
                rad_next[l]  = in_rad[l];
            end
            else if (rem_sh >= trial)
            begin
                rem_next[l]  = (RS+2)'(rem_sh - trial);
                root_next[l] = {in_root[l][RS-2:0], 1'b1};
                rad_next[l]  = in_rad[l] << 2;
            end
            else
            begin
                rem_next[l]  = (RS+2)'(rem_sh);
                root_next[l] = {in_root[l][RS-2:0], 1'b0};
                rad_next[l]  = in_rad[l] << 2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (ce)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce && in_valid)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            rad_reg   <= rad_next;
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            flags_reg <= in_flags;
            sx_reg    <= in_sx;
            sy_reg    <= in_sy;
        end
    end

    assign out_valid = v_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_flags = flags_reg;
    assign out_sx    = sx_reg;
    assign out_sy    = sy_reg;

endmodule

>>> sv/vac_back.sv
`timescale 1ns / 1ps

module vac_back #(
    parameter int W = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [vac_pkg::ZW-1:0] in_z,
    input  logic [2:0][W+2:0]             in_rem,
    input  logic [2:0][W:0]               in_root,
    input  vac_pkg::vac_flags_t           in_flags,
    input  logic signed [W:0]             in_sx,
    input  logic signed [W:0]             in_sy,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [vac_pkg::ANGLE_W-1:0]   angle,
    output logic [vac_pkg::LEN_W-1:0]     len1,
    output logic [vac_pkg::LEN_W-1:0]     len2,
    output logic [vac_pkg::SUM_W-1:0]     sum_x,
    output logic [vac_pkg::SUM_W-1:0]     sum_y,
    output logic [vac_pkg::SLEN_W-1:0]    sum_len,
    output vac_pkg::relation_t            relation,
    output logic                          zero
);
    import vac_pkg::*;

    localparam int RS = W + 1;

    logic                 v_reg;
    logic                 ce;
    logic signed [ZW-1:0] z_clamp, z_sel;
    logic [ZW-1:0]        z_round;
    logic [2:0][RS:0]     len_next;

    logic [ANGLE_W-1:0] angle_reg;
    logic [LEN_W-1:0]   len1_reg, len2_reg;
    logic [SUM_W-1:0]   sum_x_reg, sum_y_reg;
    logic [SLEN_W-1:0]  sum_len_reg;
    relation_t          relation_reg;
    logic               zero_reg;

    assign ce = !v_reg || out_ready;
    assign in_ready = ce;

    always_comb
    begin
        if (in_z < 0)
            z_clamp = '0;
        else if (in_z > DEG180_Q16)
            z_clamp = DEG180_Q16;
        else
            z_clamp = in_z;

        priority if (in_flags.zero)
            z_sel = '0;
        else if (in_flags.cross_zero)
            z_sel = in_flags.dot_neg ? DEG180_Q16 : '0;
        else if (in_flags.dot_zero)
            z_sel = DEG90_Q16;
        else
            z_sel = z_clamp;

        z_round = unsigned'(z_sel) + ROUND_HALF;

        // Round to nearest: step up when the remainder exceeds the root.
        for (int l = 0; l < 3; l++)
        begin
            len_next[l] = (RS+1)'(in_root[l]) +
                          (RS+1)'(in_rem[l] > (RS+2)'(in_root[l]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (ce)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ce && in_valid)
        begin
            angle_reg    <= z_round[8 +: ANGLE_W];
            len1_reg     <= LEN_W'(len_next[0]);
            len2_reg     <= LEN_W'(len_next[1]);
            sum_len_reg  <= SLEN_W'(len_next[2]);
            sum_x_reg    <= SUM_W'(in_sx);
            sum_y_reg    <= SUM_W'(in_sy);
            relation_reg <= in_flags.rel;
            zero_reg     <= in_flags.zero;
        end
    end

    assign out_valid = v_reg;
    assign angle     = angle_reg;
    assign len1      = len1_reg;
    assign len2      = len2_reg;
    assign sum_x     = sum_x_reg;
    assign sum_y     = sum_y_reg;
    assign sum_len   = sum_len_reg;
    assign relation  = relation_reg;
    assign zero      = zero_reg;

endmodule

>>> test/tb_vector_angle_classifier_core.sv
`timescale 1ns / 1ps

module tb_vector_angle_classifier_core;
    import vac_pkg::*;

    localparam int CW = 16;
    localparam int IN_W = ((4 * CW + 7) / 8) * 8;
    localparam int LATENCY = 22;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1572;

    typedef struct {
        logic [ANGLE_W-1:0] angle;
        logic [LEN_W-1:0]   len1;
        logic [LEN_W-1:0]   len2;
        logic [SUM_W-1:0]   sx;
        logic [SUM_W-1:0]   sy;
        logic [SLEN_W-1:0]  slen;
        relation_t          rel;
        logic               zero;
    } geometry_t;

    // Fixed-point geometry predictor and the queue of pending results.
    class geometry_scoreboard;
        geometry_t pending[$];
        int errors;
        int checked;

        static function longint unsigned root_round(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end
                else
                begin
                    r >>= 1;
                end
                b >>= 2;
            end
            if (n > r) r++;
            return r;
        endfunction

        static function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        static function longint rotate_angle(longint c, longint d);
            longint x;
            longint y;
            longint z;
            longint xo;
            if (d < 0)
            begin
                x = c; y = -d; z = DEG90_Q16;
            end
            else
            begin
                x = d; y = c; z = 0;
            end
            for (int i = 0; i < 16; i++)
            begin
                xo = x;
                if (y > 0)
                begin
                    x = x + fshift(y, i);
                    y = y - fshift(xo, i);
                    z += ATAN_TABLE[i];
                end
                else
                begin
                    x = x - fshift(y, i);
                    y = y + fshift(xo, i);
                    z -= ATAN_TABLE[i];
                end
            end
            if (z < 0) z = 0;
            if (z > DEG180_Q16) z = DEG180_Q16;
            return z;
        endfunction

        function void note_pair(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                logic signed [CW-1:0] bx, logic signed [CW-1:0] by);
            geometry_t g;
            longint x1, y1, x2, y2, sx, sy, dotp, crossp, n1, n2, z;
            x1 = ax; y1 = ay; x2 = bx; y2 = by;
            sx = x1 + x2;
            sy = y1 + y2;
            dotp = x1 * x2 + y1 * y2;
            crossp = x1 * y2 - y1 * x2;
            if (crossp < 0) crossp = -crossp;
            n1 = x1 * x1 + y1 * y1;
            n2 = x2 * x2 + y2 * y2;
            g.zero = (n1 == 0) || (n2 == 0);
            if (g.zero) z = 0;
            else if (crossp == 0) z = (dotp >= 0) ? 0 : DEG180_Q16;
            else if (dotp == 0) z = DEG90_Q16;
            else z = rotate_angle(crossp, dotp);
            g.angle = ANGLE_W'((z + 128) >> 8);
            if (dotp != 0) g.rel = REL_NOT_ORTHO;
            else if (n1 == UNIT_SQ && n2 == UNIT_SQ) g.rel = REL_ORTHONORMAL;
            else g.rel = REL_ORTHOGONAL;
            g.len1 = LEN_W'(root_round(n1));
            g.len2 = LEN_W'(root_round(n2));
            g.sx = SUM_W'(sx);
            g.sy = SUM_W'(sy);
            g.slen = SLEN_W'(root_round(sx * sx + sy * sy));
            pending.push_back(g);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] d, logic [2:0] u);
            geometry_t g;
            if (pending.size() == 0)
            begin
                report("unexpected result", d[15:0], 0);
                return;
            end
            g = pending.pop_front();
            checked++;
            if (d[15:0] !== g.angle) report("angle_degrees", d[15:0], g.angle);
            if (d[31:16] !== g.len1) report("first_length", d[31:16], g.len1);
            if (d[47:32] !== g.len2) report("second_length", d[47:32], g.len2);
            if (d[64:48] !== g.sx) report("sum_x", d[64:48], g.sx);
            if (d[81:65] !== g.sy) report("sum_y", d[81:65], g.sy);
            if (d[98:82] !== g.slen) report("sum_length", d[98:82], g.slen);
            if (u[1:0] !== g.rel) report("relation", u[1:0], g.rel);
            if (u[2] !== g.zero) report("zero_vector", u[2], g.zero);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0] m_tuser;

    geometry_scoreboard board;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_off;
    int quiet_cycles;

    vector_angle_classifier_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog on cycles with no accepted transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The valid flag stays high after a transfer so that a following pair can
    // go out in the very next cycle; idling and draining lower it.
    task send_pair(logic [CW-1:0] ax, logic [CW-1:0] ay, logic [CW-1:0] bx,
                   logic [CW-1:0] by);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {by, bx, ay, ax};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_pair(ax, ay, bx, by);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    // Random coordinate: mostly small magnitudes, sometimes full range, within unit size, or zero.
    function logic [CW-1:0] pick_coord();
        case ($urandom_range(5))
            0: return CW'($urandom);
            1: return CW'(int'($urandom_range(512)) - 256);
            2: return CW'(int'($urandom_range(16)) - 8);
            3: return '0;
            default: return CW'(int'($urandom_range(4096)) - 2048);
        endcase
    endfunction

    task random_pair();
        logic [CW-1:0] ax, ay, bx, by;
        int k;
        ax = pick_coord();
        ay = pick_coord();
        bx = pick_coord();
        by = pick_coord();
        k = $urandom_range(9);
        // Perpendicular and collinear pairs exercise the exact-angle paths.
        if (k == 0)
        begin
            bx = -ay; by = ax;
        end
        else if (k == 1)
        begin
            bx = ax << 1; by = ay << 1;
        end
        else if (k == 2)
        begin
            bx = -ax; by = -ay;
        end
        send_pair(ax, ay, bx, by);
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        hold_off = 0;
        quiet_cycles = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, zero vectors, unit vectors, collinear and perpendicular cases.
        send_pair(16'h0100, 16'h0000, 16'h0000, 16'h0100);
        send_pair(16'h0000, 16'hFF00, 16'hFF00, 16'h0000);
        send_pair(16'h0200, 16'h0000, 16'h0000, 16'h0300);
        send_pair(16'h0000, 16'h0000, 16'h0100, 16'h0100);
        send_pair(16'h0100, 16'h0100, 16'h0000, 16'h0000);
        send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
        send_pair(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_pair(16'h0100, 16'h0000, 16'hFF00, 16'h0000);
        send_pair(16'h0300, 16'h0100, 16'h0600, 16'h0200);
        send_pair(16'h0100, 16'h0000, 16'h0100, 16'h0001);
        send_pair(16'h0100, 16'h0000, 16'hFF00, 16'h0001);
        send_pair(16'h00B5, 16'h00B5, 16'h00B5, 16'hFF4B);
        send_pair(16'h0001, 16'h0001, 16'hFFFF, 16'h0001);
        send_pair(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        send_pair(16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0);
        drain();

        // Long receiver hold-off while the sender keeps offering pairs.
        hold_off = 300;
        for (int i = 0; i < 60; i++) random_pair();
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 80 : 37) : 0;
            sink_stall_pct = (ph == 2) ? 80 : ((ph == 3) ? 37 : 0);
            for (int i = 0; i < RANDOM_ITEMS / 4; i++) random_pair();
            drain();
        end
        src_idle_pct = 0;
        sink_stall_pct = 0;

        drain();
        repeat (LATENCY + 5) @(posedge clk);
        $display("Covered %0d vector pairs: extremes, zero, unit, collinear and",
                 board.checked);
        $display("perpendicular pairs under idle, stall and backpressure phases.");
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
